>>> rtl/cte_pkg.sv
package cte_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_BITS   = 4;
   localparam int TIME_BITS   = 32;
   localparam int TICKS_BITS  = 26;
   localparam int TPS_BITS    = 10;
   localparam int SECS_BITS   = 16;
   localparam int CSR_BITS    = 10;
   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [2:0] {
      OP_START  = 3'd0,
      OP_STOP   = 3'd1,
      OP_TICK   = 3'd2,
      OP_POLL   = 3'd3,
      OP_REQ    = 3'd4,
      OP_RESULT = 3'd5,
      OP_RSVD6  = 3'd6,
      OP_RSVD7  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      REG_TPS       = 3'd0,
      REG_ABORT_CMD = 3'd1,
      REG_ABORT_DEV = 3'd2,
      REG_RESET_DEV = 3'd3,
      REG_RESET_BUS = 3'd4,
      REG_HUNG      = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NONE    = 2'd1,
      ST_INVALID = 2'd2,
      ST_BUSY    = 2'd3
   } status_type;

   localparam logic [3:0] CS_IDLE      = 4'd0;
   localparam logic [3:0] CS_WAITQ     = 4'd1;
   localparam logic [3:0] CS_ACTIVE    = 4'd2;
   localparam logic [3:0] CS_ABORT_CMD = 4'd3;
   localparam logic [3:0] CS_ABORT_DEV = 4'd4;
   localparam logic [3:0] CS_RESET_DEV = 4'd5;
   localparam logic [3:0] CS_RESET_BUS = 4'd6;
   localparam logic [3:0] CS_HUNG      = 4'd7;
   localparam logic [3:0] CS_DONEQ     = 4'd8;

   localparam logic [2:0] ACT_EARLY_ABORT   = 3'd0;
   localparam logic [2:0] ACT_EARLY_TIMEOUT = 3'd1;
   localparam logic [2:0] ACT_ABORT_CMD     = 3'd2;
   localparam logic [2:0] ACT_ABORT_DEV     = 3'd3;
   localparam logic [2:0] ACT_RESET_TARGET  = 3'd4;
   localparam logic [2:0] ACT_RESET_BUS     = 3'd5;
   localparam logic [2:0] ACT_INCOMPLETE    = 3'd6;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SCAN,
      FSM_RDOUT
   } fsm_type;

   typedef struct packed {
      logic [3:0]            slot_state;
      logic [TIME_BITS-1:0]  start_time;
      logic [TICKS_BITS-1:0] timeout_ticks;
   } entry_type;

   function automatic logic [3:0] state_after(input logic [2:0] act);
      logic [3:0] ns;
      unique case (act)
         ACT_EARLY_ABORT, ACT_EARLY_TIMEOUT: ns = CS_DONEQ;
         ACT_ABORT_CMD:    ns = CS_ABORT_CMD;
         ACT_ABORT_DEV:    ns = CS_ABORT_DEV;
         ACT_RESET_TARGET: ns = CS_RESET_DEV;
         ACT_RESET_BUS:    ns = CS_RESET_BUS;
         default:          ns = CS_HUNG;
      endcase
      return ns;
   endfunction

   function automatic logic [2:0] action_after(input logic [2:0] act);
      logic [2:0] na;
      if (act <= ACT_EARLY_TIMEOUT) na = ACT_ABORT_CMD;
      else if (act >= ACT_INCOMPLETE) na = ACT_INCOMPLETE;
      else na = act + 3'd1;
      return na;
   endfunction

   function automatic logic is_terminal(input logic [2:0] act);
      return (act == ACT_EARLY_ABORT) || (act == ACT_EARLY_TIMEOUT) ||
             (act >= ACT_RESET_BUS);
   endfunction

endpackage

>>> rtl/command_timeout_escalator_top.sv
// Order: start, unused codes, busy ticks/polls, results without a pending action and
//   requested or chained actions answer from EXEC through the response register; stop and
//   reads of slot state pass EXEC, then RDOUT; a tick or poll scan passes EXEC, then SCAN, one slot per cycle.
// Throughput: one request at a time; busy stays high through the response strobe.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
// Reset (sync, active high): clear time, armed/valid bits, pending action; load defaults.
module command_timeout_escalator_top import cte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_operation,
   input  logic [3:0]           req_slot,
   input  logic [15:0]          req_timeout_seconds,
   input  logic [1:0]           req_initial_state,
   input  logic [2:0]           req_requested_action,
   input  logic                 req_action_accepted,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic                 rsp_action_valid,
   output logic [3:0]           rsp_action_slot,
   output logic [2:0]           rsp_action_code,
   output logic [3:0]           rsp_new_state,
   output logic                 rsp_recovery_done,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]  csr_write_data
);

   // configuration registers
   logic [TPS_BITS-1:0] tps_ff;
   logic [7:0] abort_cmd_ff, abort_dev_ff, reset_dev_ff, reset_bus_ff, hung_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_BITS'(100);
         abort_cmd_ff <= 8'd3;
         abort_dev_ff <= 8'd3;
         reset_dev_ff <= 8'd8;
         reset_bus_ff <= 8'd10;
         hung_ff      <= 8'd60;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_TPS:       tps_ff       <= csr_write_data;
            REG_ABORT_CMD: abort_cmd_ff <= csr_write_data[7:0];
            REG_ABORT_DEV: abort_dev_ff <= csr_write_data[7:0];
            REG_RESET_DEV: reset_dev_ff <= csr_write_data[7:0];
            REG_RESET_BUS: reset_bus_ff <= csr_write_data[7:0];
            REG_HUNG:      hung_ff      <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // slot memory: one write and one registered read port
   entry_type mem [SLOTS];
   entry_type rdata_ff;
   logic      rvalid_ff;
   logic      wr_en;
   logic [SLOT_BITS-1:0] wr_addr, rd_addr;
   entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   // control state
   fsm_type fsm_ff, fsm_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [SLOTS-1:0] armed_ff, armed_in, csv_ff, csv_in;
   logic pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pslot_ff, pslot_in;
   logic [2:0] pact_ff, pact_in;
   logic [SLOT_BITS-1:0] rd_idx_ff, rd_idx_in, chk_idx_ff, chk_idx_in;
   logic chk_vld_ff, chk_vld_in;

   // captured request
   op_type op_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [SECS_BITS-1:0] secs_ff;
   logic [1:0] init_ff;
   logic [2:0] reqact_ff;
   logic acc_ff;

   // response registers; rd_cs gives the slot state from read data
   logic rv_ff, rv_in;
   logic [1:0] st_ff, st_in;
   logic av_ff, av_in;
   logic [3:0] as_ff, as_in;
   logic [2:0] ac_ff, ac_in;
   logic [3:0] ns_ff, ns_in;
   logic dn_ff, dn_in;

   logic [3:0] rd_cs;
   assign rd_cs = rvalid_ff ? rdata_ff.slot_state : CS_IDLE;

   // issue path
   logic [SLOT_BITS-1:0] is_slot;
   logic [2:0] is_act;
   logic [3:0] is_ns;
   logic [7:0] is_secs;
   logic [TICKS_BITS-1:0] is_ticks, start_ticks;

   assign is_ns = state_after(is_act);
   always_comb begin
      unique case (is_ns)
         CS_ABORT_CMD: is_secs = abort_cmd_ff;
         CS_ABORT_DEV: is_secs = abort_dev_ff;
         CS_RESET_DEV: is_secs = reset_dev_ff;
         CS_RESET_BUS: is_secs = reset_bus_ff;
         CS_HUNG:      is_secs = hung_ff;
         default:      is_secs = 8'd0;
      endcase
   end
   assign is_ticks    = TICKS_BITS'(is_secs) * TICKS_BITS'(tps_ff);
   assign start_ticks = TICKS_BITS'(secs_ff) * TICKS_BITS'(tps_ff);

   // expiry check on the slot whose read data is now registered
   logic [TIME_BITS-1:0] elapsed;
   logic expired;
   assign elapsed = time_ff - rdata_ff.start_time;
   assign expired = armed_ff[chk_idx_ff] && (rdata_ff.timeout_ticks != '0) &&
                    (elapsed >= TIME_BITS'(rdata_ff.timeout_ticks));

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff     <= FSM_IDLE;
         time_ff    <= '0;
         armed_ff   <= '0;
         csv_ff     <= '0;
         pend_ff    <= 1'b0;
         pslot_ff   <= '0;
         pact_ff    <= '0;
         rd_idx_ff  <= '0;
         chk_idx_ff <= '0;
         chk_vld_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         fsm_ff     <= fsm_in;
         time_ff    <= time_in;
         armed_ff   <= armed_in;
         csv_ff     <= csv_in;
         pend_ff    <= pend_in;
         pslot_ff   <= pslot_in;
         pact_ff    <= pact_in;
         rd_idx_ff  <= rd_idx_in;
         chk_idx_ff <= chk_idx_in;
         chk_vld_ff <= chk_vld_in;
         rv_ff      <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rvalid_ff <= csv_ff[rd_addr];
      st_ff <= st_in;
      av_ff <= av_in;
      as_ff <= as_in;
      ac_ff <= ac_in;
      ns_ff <= ns_in;
      dn_ff <= dn_in;
      if (start && !busy) begin
         op_ff     <= op_type'(req_operation);
         slot_ff   <= req_slot;
         secs_ff   <= req_timeout_seconds;
         init_ff   <= req_initial_state;
         reqact_ff <= req_requested_action;
         acc_ff    <= req_action_accepted;
      end
   end

   always_comb begin
      fsm_in     = fsm_ff;
      time_in    = time_ff;
      armed_in   = armed_ff;
      csv_in     = csv_ff;
      pend_in    = pend_ff;
      pslot_in   = pslot_ff;
      pact_in    = pact_ff;
      rd_idx_in  = rd_idx_ff;
      chk_idx_in = chk_idx_ff;
      chk_vld_in = chk_vld_ff;
      rv_in = 1'b0;
      st_in = st_ff;
      av_in = 1'b0;
      as_in = as_ff;
      ac_in = 3'd0;
      ns_in = ns_ff;
      dn_in = 1'b0;
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      wr_data = '{slot_state: 4'(init_ff), start_time: time_ff, timeout_ticks: start_ticks};
      rd_addr = slot_ff;
      is_slot = slot_ff;
      is_act  = reqact_ff;

      unique case (fsm_ff)
         FSM_IDLE: begin
            if (start && !busy) begin
               // advance time at acceptance so the scan sees the new count
               if (op_type'(req_operation) == OP_TICK) time_in = time_ff + 1'b1;
               fsm_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            fsm_in = FSM_IDLE;
            st_in = ST_OK;
            as_in = slot_ff;
            ns_in = CS_IDLE;
            unique case (op_ff)
               OP_START: begin
                  wr_en = 1'b1;
                  armed_in[slot_ff] = 1'b1;
                  csv_in[slot_ff]   = 1'b1;
                  rv_in = 1'b1;
                  ns_in = 4'(init_ff);
               end
               OP_STOP: begin
                  armed_in[slot_ff] = 1'b0;
                  fsm_in = FSM_RDOUT;
               end
               OP_TICK, OP_POLL: begin
                  if (pend_ff) begin
                     rv_in = 1'b1;
                     st_in = ST_BUSY;
                     as_in = '0;
                  end else begin
                     rd_idx_in  = '0;
                     chk_vld_in = 1'b0;
                     fsm_in = FSM_SCAN;
                  end
               end
               OP_REQ: begin
                  if (pend_ff) begin
                     st_in = ST_BUSY;
                     fsm_in = FSM_RDOUT;
                  end else begin
                     wr_en = 1'b1;
                     wr_data = '{slot_state: is_ns, start_time: time_ff, timeout_ticks: is_ticks};
                     armed_in[is_slot] = (is_secs != 8'd0);
                     csv_in[is_slot] = 1'b1;
                     pend_in = 1'b1; pslot_in = is_slot; pact_in = is_act;
                     rv_in = 1'b1; av_in = 1'b1; ac_in = is_act; ns_in = is_ns;
                  end
               end
               OP_RESULT: begin
                  rd_addr = pslot_ff;
                  as_in = pslot_ff;
                  if (!pend_ff) begin
                     rv_in = 1'b1;
                     st_in = ST_NONE;
                     as_in = '0;
                  end else if (acc_ff) begin
                     pend_in = 1'b0;
                     fsm_in = FSM_RDOUT;
                  end else if (is_terminal(pact_ff)) begin
                     armed_in[pslot_ff] = 1'b0;
                     pend_in = 1'b0;
                     fsm_in = FSM_RDOUT;
                  end else begin
                     // refused: issue the next action of the chain
                     is_slot = pslot_ff;
                     is_act  = action_after(pact_ff);
                     wr_en   = 1'b1;
                     wr_addr = pslot_ff;
                     wr_data = '{slot_state: is_ns, start_time: time_ff, timeout_ticks: is_ticks};
                     armed_in[is_slot] = (is_secs != 8'd0);
                     csv_in[is_slot] = 1'b1;
                     pend_in = 1'b1; pslot_in = is_slot; pact_in = is_act;
                     rv_in = 1'b1; av_in = 1'b1; ac_in = is_act; ns_in = is_ns;
                  end
               end
               default: begin
                  rv_in = 1'b1;
                  as_in = '0;
               end
            endcase
         end
         FSM_RDOUT: begin
            // read data for the concerned slot is registered now
            rv_in = 1'b1;
            ns_in = rd_cs;
            dn_in = (op_ff == OP_RESULT) && !acc_ff;
            fsm_in = FSM_IDLE;
         end
         FSM_SCAN: begin
            rd_addr = rd_idx_ff;
            if (chk_vld_ff && expired) begin
               armed_in[chk_idx_ff] = 1'b0;
               fsm_in = FSM_IDLE;
               rv_in = 1'b1;
               as_in = chk_idx_ff;
               is_slot = chk_idx_ff;
               priority if (rd_cs >= CS_WAITQ && rd_cs <= CS_HUNG) begin
                  unique case (rd_cs)
                     CS_WAITQ:     is_act = ACT_EARLY_TIMEOUT;
                     CS_ACTIVE:    is_act = ACT_ABORT_CMD;
                     CS_ABORT_CMD: is_act = ACT_ABORT_DEV;
                     CS_ABORT_DEV: is_act = ACT_RESET_TARGET;
                     CS_RESET_DEV: is_act = ACT_RESET_BUS;
                     default:      is_act = ACT_INCOMPLETE;
                  endcase
                  wr_en   = 1'b1;
                  wr_addr = chk_idx_ff;
                  wr_data = '{slot_state: is_ns, start_time: time_ff, timeout_ticks: is_ticks};
                  armed_in[chk_idx_ff] = (is_secs != 8'd0);
                  csv_in[chk_idx_ff] = 1'b1;
                  pend_in = 1'b1; pslot_in = chk_idx_ff; pact_in = is_act;
                  st_in = ST_OK; av_in = 1'b1; ac_in = is_act; ns_in = is_ns;
               end else begin
                  st_in = ST_INVALID;
                  ns_in = rd_cs;
               end
            end else if (chk_vld_ff && chk_idx_ff == SLOT_BITS'(SLOTS - 1)) begin
               fsm_in = FSM_IDLE;
               rv_in = 1'b1;
               st_in = ST_NONE;
               as_in = '0;
               ns_in = CS_IDLE;
            end else begin
               chk_idx_in = rd_idx_ff;
               chk_vld_in = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   assign busy              = (fsm_ff != FSM_IDLE) || rv_ff;
   assign rsp_valid         = rv_ff;
   assign rsp_status        = st_ff;
   assign rsp_action_valid  = av_ff;
   assign rsp_action_slot   = as_ff;
   assign rsp_action_code   = ac_ff;
   assign rsp_new_state     = ns_ff;
   assign rsp_recovery_done = dn_ff;

endmodule

>>> verif/command_timeout_escalator_checker.sv
`timescale 1ns / 1ps

module command_timeout_escalator_checker import cte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_timeout_seconds,
   input  logic [1:0]  req_initial_state,
   input  logic [2:0]  req_requested_action,
   input  logic        req_action_accepted,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_action_valid,
   input  logic [3:0]  rsp_action_slot,
   input  logic [2:0]  rsp_action_code,
   input  logic [3:0]  rsp_new_state,
   input  logic        rsp_recovery_done,
   input  logic        csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0] csr_write_data,
   output int          errors,
   output int          outstanding,
   output logic        awaiting_answer
);

   typedef struct packed {
      logic [1:0] status;
      logic       act_valid;
      logic [3:0] act_slot;
      logic [2:0] act_code;
      logic [3:0] new_state;
      logic       done;
   } escalation_rsp_type;

   escalation_rsp_type expected_rsps[$];

   logic [9:0]  tps;
   logic [7:0]  secs_of_reg[1:5];
   logic [31:0] now;
   logic        armed[SLOTS];
   logic [31:0] t_start[SLOTS];
   logic [31:0] t_limit[SLOTS];
   logic [3:0]  cstate[SLOTS];
   logic        pend;
   logic [3:0]  pend_slot;
   logic [2:0]  pend_act;

   assign outstanding = expected_rsps.size();
   assign awaiting_answer = pend;

   function automatic escalation_rsp_type mk(logic [1:0] st, logic v, logic [3:0] s,
                                             logic [2:0] c, logic [3:0] ns, logic d);
      escalation_rsp_type r;
      r.status = st; r.act_valid = v; r.act_slot = s;
      r.act_code = c; r.new_state = ns; r.done = d;
      return r;
   endfunction

   function automatic logic [7:0] recovery_secs(logic [3:0] st);
      case (st)
         CS_ABORT_CMD: return secs_of_reg[REG_ABORT_CMD];
         CS_ABORT_DEV: return secs_of_reg[REG_ABORT_DEV];
         CS_RESET_DEV: return secs_of_reg[REG_RESET_DEV];
         CS_RESET_BUS: return secs_of_reg[REG_RESET_BUS];
         CS_HUNG:      return secs_of_reg[REG_HUNG];
         default:      return 8'd0;
      endcase
   endfunction

   function automatic logic [3:0] next_state_of(logic [2:0] a);
      case (a)
         ACT_EARLY_ABORT, ACT_EARLY_TIMEOUT: return CS_DONEQ;
         ACT_ABORT_CMD:    return CS_ABORT_CMD;
         ACT_ABORT_DEV:    return CS_ABORT_DEV;
         ACT_RESET_TARGET: return CS_RESET_DEV;
         ACT_RESET_BUS:    return CS_RESET_BUS;
         default:          return CS_HUNG;
      endcase
   endfunction

   task automatic arm_timer(int s, logic [31:0] secs);
      armed[s] = 1'b1;
      t_start[s] = now;
      t_limit[s] = secs * tps;
   endtask

   task automatic issue_action(int s, logic [2:0] a, output escalation_rsp_type r);
      logic [3:0] ns;
      logic [7:0] secs;
      ns = next_state_of(a);
      secs = recovery_secs(ns);
      cstate[s] = ns;
      armed[s] = 1'b0;
      if (secs != 0) arm_timer(s, 32'(secs));
      pend = 1'b1; pend_slot = 4'(s); pend_act = a;
      r = mk(ST_OK, 1'b1, 4'(s), a, ns, 1'b0);
   endtask

   task automatic scan_expired(output escalation_rsp_type r);
      int hit;
      logic [2:0] a;
      hit = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
         if (armed[i] && t_limit[i] != 0 && (now - t_start[i]) >= t_limit[i]) hit = i;
      if (hit < 0) begin
         r = mk(ST_NONE, 0, 0, 0, 0, 0);
         return;
      end
      armed[hit] = 1'b0;
      case (cstate[hit])
         CS_WAITQ:     a = ACT_EARLY_TIMEOUT;
         CS_ACTIVE:    a = ACT_ABORT_CMD;
         CS_ABORT_CMD: a = ACT_ABORT_DEV;
         CS_ABORT_DEV: a = ACT_RESET_TARGET;
         CS_RESET_DEV: a = ACT_RESET_BUS;
         CS_RESET_BUS, CS_HUNG: a = ACT_INCOMPLETE;
         default: begin
            r = mk(ST_INVALID, 0, 4'(hit), 0, cstate[hit], 0);
            return;
         end
      endcase
      issue_action(hit, a, r);
   endtask

   task automatic predict_request(output escalation_rsp_type r);
      int s;
      logic [2:0] a, na;
      s = req_slot;
      case (op_type'(req_operation))
         OP_START: begin
            cstate[s] = {2'b00, req_initial_state};
            arm_timer(s, 32'(req_timeout_seconds));
            r = mk(ST_OK, 0, req_slot, 0, cstate[s], 0);
         end
         OP_STOP: begin
            armed[s] = 1'b0;
            r = mk(ST_OK, 0, req_slot, 0, cstate[s], 0);
         end
         OP_TICK, OP_POLL: begin
            if (op_type'(req_operation) == OP_TICK) now = now + 1;
            if (pend) r = mk(ST_BUSY, 0, 0, 0, 0, 0);
            else scan_expired(r);
         end
         OP_REQ: begin
            if (pend) r = mk(ST_BUSY, 0, req_slot, 0, cstate[s], 0);
            else issue_action(s, req_requested_action, r);
         end
         OP_RESULT: begin
            if (!pend) r = mk(ST_NONE, 0, 0, 0, 0, 0);
            else if (req_action_accepted) begin
               pend = 1'b0;
               r = mk(ST_OK, 0, pend_slot, 0, cstate[pend_slot], 0);
            end else begin
               armed[pend_slot] = 1'b0;
               a = pend_act;
               if (a == ACT_EARLY_ABORT || a == ACT_EARLY_TIMEOUT || a >= ACT_RESET_BUS) begin
                  pend = 1'b0;
                  r = mk(ST_OK, 0, pend_slot, 0, cstate[pend_slot], 1);
               end else begin
                  na = (a <= ACT_EARLY_TIMEOUT) ? ACT_ABORT_CMD : a + 3'd1;
                  issue_action(pend_slot, na, r);
               end
            end
         end
         default: r = mk(ST_OK, 0, 0, 0, 0, 0);
      endcase
   endtask

   task automatic compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      escalation_rsp_type r, e;
      if (reset) begin
         tps = 10'd100;
         secs_of_reg[REG_ABORT_CMD] = 8'd3;
         secs_of_reg[REG_ABORT_DEV] = 8'd3;
         secs_of_reg[REG_RESET_DEV] = 8'd8;
         secs_of_reg[REG_RESET_BUS] = 8'd10;
         secs_of_reg[REG_HUNG] = 8'd60;
         now = 0;
         for (int i = 0; i < SLOTS; i++) begin
            armed[i] = 0; t_start[i] = 0; t_limit[i] = 0; cstate[i] = CS_IDLE;
         end
         pend = 0; pend_slot = 0; pend_act = 0;
         expected_rsps.delete();
         errors = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_TPS) tps = csr_write_data;
            else if (csr_index >= REG_ABORT_CMD && csr_index <= REG_HUNG)
               secs_of_reg[csr_index] = csr_write_data[7:0];
         end
         if (start && !busy) begin
            predict_request(r);
            expected_rsps.push_back(r);
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               compare_field("status", e.status, rsp_status);
               compare_field("action_valid", e.act_valid, rsp_action_valid);
               compare_field("action_slot", e.act_slot, rsp_action_slot);
               compare_field("action_code", e.act_code, rsp_action_code);
               compare_field("new_state", e.new_state, rsp_new_state);
               compare_field("recovery_done", e.done, rsp_recovery_done);
            end
         end
      end
   end

endmodule

>>> verif/command_timeout_escalator_top_test.sv
`timescale 1ns / 1ps

module command_timeout_escalator_top_test;
   import cte_pkg::*;

   logic        clock, reset, start, busy;
   logic [2:0]  req_operation;
   logic [3:0]  req_slot;
   logic [15:0] req_timeout_seconds;
   logic [1:0]  req_initial_state;
   logic [2:0]  req_requested_action;
   logic        req_action_accepted;
   logic        rsp_valid, rsp_action_valid, rsp_recovery_done;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_action_slot, rsp_new_state;
   logic [2:0]  rsp_action_code;
   logic        csr_write_enable;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0] csr_write_data;
   int          errors, outstanding;
   logic        awaiting_answer;

   command_timeout_escalator_top dut (.*);

   command_timeout_escalator_checker chk (.*);

   // Free-running clock, 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drive one request at the falling edge and hold it until accepted.
   // Start stays high on return so back-to-back requests form a burst.
   task automatic send_request(op_type op, logic [3:0] s, logic [15:0] secs,
                               logic [1:0] init, logic [2:0] act, logic acc);
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_slot <= s;
      req_timeout_seconds <= secs;
      req_initial_state <= init;
      req_requested_action <= act;
      req_action_accepted <= acc;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and idle for a number of cycles.
   task automatic pause_requests(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Hold off until every response is back, then let the longest scan settle.
   task automatic drain_responses();
      pause_requests(0);
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(reg_idx_type idx, logic [CSR_BITS-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_settings(logic [9:0] tps, logic [7:0] ac, logic [7:0] ad,
                                logic [7:0] rd, logic [7:0] rb, logic [7:0] hg);
      write_csr(REG_TPS, tps);
      write_csr(REG_ABORT_CMD, ac);
      write_csr(REG_ABORT_DEV, ad);
      write_csr(REG_RESET_DEV, rd);
      write_csr(REG_RESET_BUS, rb);
      write_csr(REG_HUNG, hg);
   endtask

   // Random request, steered toward answering pending actions so escalation
   // chains run deep; the rest is ticks, polls and slot traffic.
   task automatic random_request();
      int pick;
      logic [15:0] secs;
      op_type op;
      pick = $urandom_range(0, 99);
      if (awaiting_answer && pick < 55) op = OP_RESULT;
      else if (pick < 40) op = OP_TICK;
      else if (pick < 50) op = OP_POLL;
      else if (pick < 68) op = OP_START;
      else if (pick < 75) op = OP_STOP;
      else if (pick < 85) op = OP_REQ;
      else if (pick < 96) op = OP_RESULT;
      else op = op_type'($urandom_range(6, 7));
      case ($urandom_range(0, 9))
         0:       secs = 16'($urandom);
         1:       secs = 16'd0;
         default: secs = 16'($urandom_range(1, 6));
      endcase
      send_request(op, 4'($urandom), secs,
                   (op == OP_START) ? 2'($urandom_range(1, 2)) : 2'($urandom),
                   3'($urandom_range(0, 6)), 1'($urandom));
   endtask

   task automatic random_phase(int n);
      int left;
      left = n;
      while (left > 0) begin
         // Burst of back-to-back requests, then a gap (sometimes none).
         for (int k = $urandom_range(1, 12); k > 0 && left > 0; k--) begin
            random_request();
            left--;
         end
         if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(0, 7));
      end
      drain_responses();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_TICK;
      req_slot = '0;
      req_timeout_seconds = '0;
      req_initial_state = '0;
      req_requested_action = '0;
      req_action_accepted = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: short timers, arm every slot so no state read hits unwritten memory.
      load_settings(10'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1);
      for (int s = 0; s < SLOTS; s++)
         send_request(OP_START, 4'(s), (s == 0) ? 16'd0 : (s == 15) ? 16'hFFFF : 16'd1,
                      (s % 2) ? 2'd1 : 2'd2, '0, 1'b0);
      send_request(OP_POLL, '0, '0, '0, '0, 1'b0);     // nothing expired yet
      send_request(OP_TICK, '0, '0, '0, '0, 1'b0);     // slot 1 expires from waitq
      send_request(OP_TICK, '0, '0, '0, '0, 1'b0);     // busy while pending
      send_request(OP_REQ, 4'd3, '0, '0, ACT_RESET_BUS, 1'b0); // busy request
      send_request(OP_RESULT, '0, '0, '0, '0, 1'b0);   // refused terminal action
      send_request(OP_RESULT, '0, '0, '0, '0, 1'b1);   // result with nothing pending
      send_request(OP_REQ, 4'd5, '0, '0, ACT_ABORT_CMD, 1'b0);
      send_request(OP_RESULT, '0, '0, '0, '0, 1'b0);   // advance to abort dev
      send_request(OP_RESULT, '0, '0, '0, '0, 1'b0);   // advance to reset target
      send_request(OP_RESULT, '0, '0, '0, '0, 1'b1);   // accepted
      send_request(OP_REQ, 4'd6, '0, '0, ACT_INCOMPLETE, 1'b0);
      send_request(OP_RESULT, '0, '0, '0, '0, 1'b1);
      send_request(OP_REQ, 4'd7, '0, '0, ACT_EARLY_ABORT, 1'b0);
      send_request(OP_RESULT, '0, '0, '0, '0, 1'b0);
      send_request(OP_STOP, 4'd2, '0, '0, '0, 1'b0);
      send_request(OP_RSVD6, '0, '0, '0, '0, 1'b0);
      send_request(OP_RSVD7, 4'hF, 16'hFFFF, 2'd3, 3'd7, 1'b1);
      drain_responses();

      // Random phases across settings, including register extremes.
      random_phase(200);
      load_settings(10'd1, 8'd0, 8'd1, 8'd0, 8'd2, 8'd0);
      random_phase(200);
      load_settings(10'd2, 8'd255, 8'd1, 8'd1, 8'd255, 8'd1);
      random_phase(180);
      load_settings(10'd1000, 8'd1, 8'd1, 8'd1, 8'd1, 8'd255);
      random_phase(80);
      load_settings(10'd1, 8'd3, 8'd2, 8'd1, 8'd1, 8'd1);
      random_phase(240);

      if (errors == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
rtl/cte_pkg.sv
rtl/command_timeout_escalator_top.sv
verif/command_timeout_escalator_checker.sv
verif/command_timeout_escalator_top_test.sv
